FILE: hw/rtl/crcfc_pkg.sv
package crcfc_pkg;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_OFFSET   = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [POS_W-1:0] FRAME_LENGTH_RESET = 10'd120;
    localparam logic [POS_W-1:0] CRC_OFFSET_RESET   = 10'd40;

    // Per-byte outcome of the frame tracker.
    typedef struct packed {
        logic             last;
        logic             ok;
        logic [CRC_W-1:0] computed;
        logic [CRC_W-1:0] received;
    } t_frame_info;

endpackage

FILE: hw/rtl/crcfc_crc_step.sv
module crcfc_crc_step (
    input  logic [crcfc_pkg::CRC_W-1:0]  i_crc,
    input  logic [crcfc_pkg::BYTE_W-1:0] i_byte,
    output logic [crcfc_pkg::CRC_W-1:0]  o_crc
);
    import crcfc_pkg::*;

    // Eight unrolled shift steps of the MSB-first CRC, one per data bit.
    always_comb begin
        logic [CRC_W-1:0] v_crc;
        v_crc = i_crc ^ {i_byte, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((v_crc & CRC_TOP) != '0) begin
                v_crc = {v_crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

FILE: hw/rtl/crcfc_frame_track.sv
module crcfc_frame_track (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [crcfc_pkg::BYTE_W-1:0] i_byte,
    input  logic [crcfc_pkg::POS_W-1:0]  i_frame_length,
    input  logic [crcfc_pkg::POS_W-1:0]  i_crc_offset,
    output crcfc_pkg::t_frame_info       o_info
);
    import crcfc_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [CRC_W-1:0]  r_crc;
    logic [CRC_W-1:0]  r_cap;
    logic [POS_W-1:0]  n_pos;
    logic [CRC_W-1:0]  n_crc;
    logic [CRC_W-1:0]  n_cap;

    logic [POS_W-1:0]  len_eff;
    logic              at_lo;
    logic              at_hi;
    logic [BYTE_W-1:0] fed_byte;
    logic [CRC_W-1:0]  crc_next;
    logic [CRC_W-1:0]  cap_next;
    logic              is_last;

    // A frame length of zero behaves as a one-byte frame.
    assign len_eff = (i_frame_length == '0) ? POS_W'(1) : i_frame_length;

    // Locate the embedded CRC field; the high byte may sit one past the offset range.
    assign at_lo = (r_pos == i_crc_offset);
    assign at_hi = ({1'b0, r_pos} == ({1'b0, i_crc_offset} + (POS_W+1)'(1)));

    // Capture the field, low byte first, and feed zeros in its place.
    always_comb begin
        cap_next = r_cap;
        fed_byte = i_byte;
        if (at_lo) begin
            cap_next = {r_cap[CRC_W-1:BYTE_W], i_byte};
            fed_byte = '0;
        end else if (at_hi) begin
            cap_next = {i_byte, r_cap[BYTE_W-1:0]};
            fed_byte = '0;
        end
    end

    crcfc_crc_step u_crc_step (
        .i_crc  (r_crc),
        .i_byte (fed_byte),
        .o_crc  (crc_next)
    );

    // The byte ends the frame once the position reaches the last slot or beyond.
    assign is_last = !(({1'b0, r_pos} + (POS_W+1)'(1)) < {1'b0, len_eff});

    assign o_info.last     = is_last;
    assign o_info.ok       = (cap_next == crc_next);
    assign o_info.computed = crc_next;
    assign o_info.received = cap_next;

    // Advance the frame state, restarting it after the last byte.
    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        n_cap = r_cap;
        if (i_step) begin
            if (is_last) begin
                n_pos = '0;
                n_crc = CRC_INIT;
                n_cap = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_crc = crc_next;
                n_cap = cap_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
            r_cap <= '0;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_cap <= n_cap;
        end
    end

endmodule

FILE: hw/rtl/crc16_frame_checker_unit.sv
// CRC-16/CCITT-FALSE frame checker. Bytes of fixed-length frames enter on the input
// channel, one transfer per byte; the two bytes at crc_offset (low byte first) are the
// embedded CRC and enter the CRC as zeros. On the last byte of each frame one result
// leaves with the pass flag, both CRC values and the saturating count of failed frames.
// The block takes one byte per clock cycle while it does not stall. A held byte in the
// input register passes through the unrolled eight-bit CRC step into the frame state,
// and a frame's result is loaded into the result register when its last byte moves on
// out of the input register. The result register lets the next bytes keep flowing while
// a result waits; input stalls only once the last byte of the next frame meets a result
// that has not yet been taken. Configuration writes take effect at once and do not
// restart a frame in progress.
module crc16_frame_checker_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_wr_en,
    input  logic [crcfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crcfc_pkg::POS_W-1:0]     i_cfg_data,
    // Input byte channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [crcfc_pkg::BYTE_W-1:0]    i_data_byte,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_frame_ok,
    output logic [crcfc_pkg::CRC_W-1:0]     o_computed_crc,
    output logic [crcfc_pkg::CRC_W-1:0]     o_received_crc,
    output logic [crcfc_pkg::COUNT_W-1:0]   o_error_total
);
    import crcfc_pkg::*;

    logic [POS_W-1:0]   r_frame_length;
    logic [POS_W-1:0]   r_crc_offset;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               n_in_valid;

    logic               r_out_valid;
    logic               r_out_ok;
    logic [CRC_W-1:0]   r_out_computed;
    logic [CRC_W-1:0]   r_out_received;
    logic [COUNT_W-1:0] r_out_errors;
    logic               n_out_valid;

    logic [COUNT_W-1:0] r_err_cnt;
    logic [COUNT_W-1:0] n_err_cnt;

    t_frame_info        info;
    logic               in_xfer;
    logic               advance;
    logic               load_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FRAME_LENGTH_RESET;
            r_crc_offset   <= CRC_OFFSET_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data;
                CFG_CRC_OFFSET:   r_crc_offset   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // The held byte moves on unless it closes a frame and the result slot is blocked.
    assign advance    = r_in_valid && (!info.last || !r_out_valid || !i_out_stall);
    assign load_out   = advance && info.last;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Input register.
    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_data_byte;
        end
    end

    crcfc_frame_track u_frame_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_byte         (r_in_byte),
        .i_frame_length (r_frame_length),
        .i_crc_offset   (r_crc_offset),
        .o_info         (info)
    );

    // Saturating count of failed frames, this frame included.
    always_comb begin
        n_err_cnt = r_err_cnt;
        if (!info.ok && (r_err_cnt != {COUNT_W{1'b1}})) begin
            n_err_cnt = r_err_cnt + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_cnt <= '0;
        end else if (load_out) begin
            r_err_cnt <= n_err_cnt;
        end
    end

    // Result register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_ok       <= info.ok;
            r_out_computed <= info.computed;
            r_out_received <= info.received;
            r_out_errors   <= n_err_cnt;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_ok     = r_out_ok;
    assign o_computed_crc = r_out_computed;
    assign o_received_crc = r_out_received;
    assign o_error_total  = r_out_errors;

    // Input stalls only while a byte is held that cannot move on.
    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // A new result appears only after a held byte closed a frame.
    a_result_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a byte behind it");

    // The pass flag agrees with the two CRC values it reports.
    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_ok == (o_computed_crc == o_received_crc)))
        else $error("pass flag disagrees with the reported CRC values");

    // The failed-frame count never goes down.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_err_cnt >= $past(r_err_cnt)))
        else $error("failed-frame count decreased");

endmodule

FILE: bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crcfc_pkg::*;

    localparam int CLK_HALF          = 6;
    localparam int RESET_CYCLES      = 11;
    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int DRAIN_CYCLES      = 4;
    localparam int RANDOM_ITEMS      = 200;
    localparam int HOLD_CYCLES       = 400;
    localparam int PRINT_LIMIT       = 40;
    localparam int DEFAULT_FRAME_LEN = 120;
    localparam int DEFAULT_CRC_OFF   = 40;

    // Register indexes that map to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int {FRAME_GOOD, FRAME_FLIPPED, FRAME_NOISE} frame_kind_e;

    typedef struct {
        logic               ok;
        logic [CRC_W-1:0]   computed;
        logic [CRC_W-1:0]   received;
        logic [COUNT_W-1:0] total;
    } verdict_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [POS_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_frame_ok;
    logic [CRC_W-1:0]     o_computed_crc;
    logic [CRC_W-1:0]     o_received_crc;
    logic [COUNT_W-1:0]   o_error_total;

    // Frame tracker state and its copy of the configuration.
    int unsigned        frame_len_cfg = DEFAULT_FRAME_LEN;
    int unsigned        crc_off_cfg = DEFAULT_CRC_OFF;
    int unsigned        trk_pos = 0;
    logic [CRC_W-1:0]   trk_crc = CRC_INIT;
    logic [CRC_W-1:0]   trk_captured = '0;
    logic [COUNT_W-1:0] trk_fail_count = '0;
    verdict_t           expected_verdicts[$];

    // Traffic shaping.
    int unsigned  gap_max = 0;
    int unsigned  burst_left = 0;
    logic [15:0]  stall_pattern = '0;
    logic         hold_on = 1'b0;
    int unsigned  cycle_count = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  fault_count = 0;

    crc16_frame_checker_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_ok     (o_frame_ok),
        .o_computed_crc (o_computed_crc),
        .o_received_crc (o_received_crc),
        .o_error_total  (o_error_total)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Cycle counter with a hard limit on the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("crc16_frame_checker_unit: mismatch");
            $finish;
        end
    end

    // Result-side stall: a rotating pattern, overridden by a long hold-off.
    always @(posedge i_clk) begin
        i_out_stall <= hold_on | stall_pattern[cycle_count % 16];
    end

    task automatic report_error(input string what);
        if (fault_count < PRINT_LIMIT) begin
            $display("[%0t] ERROR: %s", $time, what);
        end
        fault_count++;
    endtask

    // One byte through CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        r = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // Advance the frame tracker by one accepted byte; queue a verdict at frame end.
    function automatic void track_byte(input logic [BYTE_W-1:0] data);
        int unsigned       len;
        logic [BYTE_W-1:0] fed;
        verdict_t          v;
        len = (frame_len_cfg == 0) ? 1 : frame_len_cfg;
        fed = data;
        if (trk_pos == crc_off_cfg) begin
            trk_captured[7:0] = data;
            fed = '0;
        end else if (trk_pos == crc_off_cfg + 1) begin
            trk_captured[15:8] = data;
            fed = '0;
        end
        trk_crc = crc16_step(trk_crc, fed);
        if (trk_pos + 1 < len) begin
            trk_pos++;
            return;
        end
        v.ok = (trk_captured == trk_crc);
        if (!v.ok && trk_fail_count != '1) begin
            trk_fail_count++;
        end
        v.computed = trk_crc;
        v.received = trk_captured;
        v.total    = trk_fail_count;
        expected_verdicts.push_back(v);
        trk_pos      = 0;
        trk_crc      = CRC_INIT;
        trk_captured = '0;
    endfunction

    // Compare every result transfer with the oldest pending verdict.
    always @(posedge i_clk) begin : result_check
        verdict_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_verdicts.size() == 0) begin
                report_error($sformatf("result with no frame pending (computed %h)",
                                       o_computed_crc));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_frame_ok !== want.ok) begin
                    report_error($sformatf("frame_ok %b, want %b", o_frame_ok, want.ok));
                end
                if (o_computed_crc !== want.computed) begin
                    report_error($sformatf("computed_crc %h, want %h",
                                           o_computed_crc, want.computed));
                end
                if (o_received_crc !== want.received) begin
                    report_error($sformatf("received_crc %h, want %h",
                                           o_received_crc, want.received));
                end
                if (o_error_total !== want.total) begin
                    report_error($sformatf("error_total %0d, want %0d",
                                           o_error_total, want.total));
                end
            end
        end
    end

    // Offer one byte and wait for its transfer; the sender idles between bursts.
    task automatic send_byte(input logic [BYTE_W-1:0] data);
        int unsigned gap;
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(gap_max, 1);
                burst_left = $urandom_range(24, 1);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_byte(data);
        bytes_sent++;
    endtask

    // Stop offering and wait until every verdict is in and the pipeline is empty.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Registers are written only once no byte or result is left in the block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[POS_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_FRAME_LENGTH) begin
            frame_len_cfg = value[POS_W-1:0];
        end else if (idx == CFG_CRC_OFFSET) begin
            crc_off_cfg = value[POS_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned len, input int unsigned off);
        write_reg(CFG_FRAME_LENGTH, len);
        write_reg(CFG_CRC_OFFSET, off);
    endtask

    // Build one frame for the current settings and send it.
    // A good frame carries its own CRC; a flipped one has a single bit error.
    task automatic send_frame(input frame_kind_e kind);
        int unsigned       len;
        int unsigned       pick;
        logic [BYTE_W-1:0] bytes[];
        logic [CRC_W-1:0]  crc;
        len = (frame_len_cfg == 0) ? 1 : frame_len_cfg;
        bytes = new[len];
        foreach (bytes[i]) bytes[i] = BYTE_W'($urandom_range(255, 0));
        if (kind != FRAME_NOISE) begin
            crc = CRC_INIT;
            for (int unsigned i = 0; i < len; i++) begin
                crc = crc16_step(crc, (i == crc_off_cfg || i == crc_off_cfg + 1) ?
                                      8'h00 : bytes[i]);
            end
            if (crc_off_cfg < len) bytes[crc_off_cfg] = crc[7:0];
            if (crc_off_cfg + 1 < len) bytes[crc_off_cfg + 1] = crc[15:8];
        end
        if (kind == FRAME_FLIPPED) begin
            pick = $urandom_range(len - 1, 0);
            bytes[pick] = bytes[pick] ^ (8'h01 << $urandom_range(7, 0));
        end
        foreach (bytes[i]) send_byte(bytes[i]);
    endtask

    // New idling profile for both sides; the stall pattern always keeps a free slot.
    function automatic void shuffle_traffic();
        gap_max = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(8, 1);
        if ($urandom_range(9, 0) < 3) begin
            stall_pattern = '0;
        end else begin
            stall_pattern = 16'($urandom) & ~(16'h1 << $urandom_range(15, 0));
        end
    endfunction

    // Settings mostly place the field inside the frame; some push it to or past the end.
    task automatic random_config();
        int unsigned len;
        int unsigned eff;
        int unsigned off;
        int unsigned r;
        r = $urandom_range(19, 0);
        if (r == 0) begin
            len = $urandom_range(2, 0);
        end else if (r < 4) begin
            len = $urandom_range(64, 25);
        end else begin
            len = $urandom_range(24, 3);
        end
        eff = (len == 0) ? 1 : len;
        r = $urandom_range(19, 0);
        if (r == 0 || eff < 2) begin
            off = $urandom_range(1023, 0);
        end else if (r == 1) begin
            off = eff - 1 + $urandom_range(1, 0);
        end else begin
            off = $urandom_range(eff - 2, 0);
        end
        configure(len, off);
    endtask

    // Reset values: one well-formed frame at the default length and offset.
    task automatic test_reset_config();
        gap_max = 3;
        stall_pattern = 16'h0F0F;
        send_frame(FRAME_GOOD);
    endtask

    // Short frames with the CRC field at the start, the end and beyond the frame.
    task automatic test_short_frames();
        wait_drained();
        gap_max = 2;
        stall_pattern = 16'h5555;
        configure(3, 0);
        send_frame(FRAME_GOOD);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        // Field ends on the last byte of the frame.
        configure(3, 1);
        send_frame(FRAME_GOOD);
        // Only the low byte of the field falls inside the frame.
        configure(3, 2);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // Field wholly outside the frame: nothing is captured.
        configure(3, 1023);
        send_frame(FRAME_GOOD);
        // Lengths below the legal minimum, zero acting as one.
        configure(2, 0);
        send_frame(FRAME_GOOD);
        configure(1, 0);
        send_byte(8'hFF);
        send_byte(8'h00);
        configure(0, 0);
        send_byte(BYTE_W'($urandom_range(255, 0)));
        send_byte(BYTE_W'($urandom_range(255, 0)));
    endtask

    // Shrinking the frame below the bytes already taken ends it on the next byte.
    task automatic test_midframe_shrink();
        wait_drained();
        configure(6, 0);
        repeat (3) send_byte(BYTE_W'($urandom_range(255, 0)));
        wait_drained();
        write_reg(CFG_FRAME_LENGTH, 2);
        send_byte(BYTE_W'($urandom_range(255, 0)));
    endtask

    // Writes to unused indexes must leave both registers alone.
    task automatic test_spare_registers();
        wait_drained();
        write_reg(CFG_SPARE_A, 10'h3FF);
        write_reg(CFG_SPARE_B, 10'h001);
        send_frame(FRAME_GOOD);
    endtask

    // Mostly well-formed frames with random content, some corrupted, some noise.
    task automatic test_random_frames();
        int unsigned start;
        int unsigned r;
        frame_kind_e kind;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS) begin
            wait_drained();
            random_config();
            shuffle_traffic();
            repeat ($urandom_range(12, 4)) begin
                r = $urandom_range(99, 0);
                kind = (r < 75) ? FRAME_GOOD : (r < 87) ? FRAME_FLIPPED : FRAME_NOISE;
                send_frame(kind);
            end
        end
    endtask

    // Longest frame with the field at the last legal offset.
    task automatic test_max_frame();
        wait_drained();
        gap_max = 0;
        stall_pattern = '0;
        configure(1023, 1021);
        send_frame(FRAME_GOOD);
    endtask

    // Results held off for a long stretch while bytes keep coming, so input stalls.
    task automatic test_backpressure();
        wait_drained();
        gap_max = 0;
        stall_pattern = '0;
        configure(4, 1);
        fork
            begin
                hold_on = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on = 1'b0;
            end
        join_none
        repeat (12) send_frame(FRAME_GOOD);
    endtask

    // One-byte frames with no field nearly always fail, so the count climbs each byte.
    task automatic test_error_count();
        wait_drained();
        gap_max = 0;
        stall_pattern = '0;
        configure(1, 1023);
        repeat (24) send_byte(BYTE_W'($urandom_range(255, 0)));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config();
        test_short_frames();
        test_midframe_shrink();
        test_spare_registers();
        test_random_frames();
        test_max_frame();
        test_backpressure();
        test_error_count();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && expected_verdicts.size() == 0) begin
            $display("crc16_frame_checker_unit: match");
        end else begin
            $display("crc16_frame_checker_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/crcfc_pkg.sv
hw/rtl/crcfc_crc_step.sv
hw/rtl/crcfc_frame_track.sv
hw/rtl/crc16_frame_checker_unit.sv
bench/tb_top.sv
